// ----- design/battery_voltage_monitor_assert.svh -----
// assertion macros used by the battery voltage monitor back end
`ifndef BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bvm_pkg.sv -----
// types and constants of the battery voltage monitor
`default_nettype none

package bvm_pkg;

  // default queue depths
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  // configuration register indexes
  localparam logic CFG_DEBOUNCE_LIMIT = 1'b0;
  localparam logic CFG_VALID_FLOOR    = 1'b1;

  // configuration reset values
  localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd100;
  localparam logic [9:0] VALID_FLOOR_RST    = 10'd200;

  // voltage thresholds in adc counts
  localparam logic [9:0] V_CRIT_MAX  = 10'd345;
  localparam logic [9:0] V_START_MAX = 10'd355;
  localparam logic [9:0] V_L0_MAX    = 10'd350;
  localparam logic [9:0] V_L1_MAX    = 10'd360;
  localparam logic [9:0] V_L2_LO     = 10'd365;
  localparam logic [9:0] V_L2_MAX    = 10'd375;
  localparam logic [9:0] V_L3_LO     = 10'd380;
  localparam logic [9:0] V_L3_MAX    = 10'd390;
  localparam logic [9:0] V_L4_LO     = 10'd395;
  localparam logic [9:0] V_L4_MAX    = 10'd405;
  localparam logic [9:0] V_L5_LO     = 10'd410;
  localparam logic [9:0] V_L5_MAX    = 10'd500;

  // sample class decided by the front end
  typedef enum logic [2:0] {
    CLS_START_LOW,
    CLS_START_OTHER,
    CLS_CRIT,
    CLS_WARN,
    CLS_OTHER
  } cls_e;

  // classified sample handed to the back end
  typedef struct packed {
    cls_e       cls;
    logic       band_hit;
    logic [2:0] band;
    logic       menu_active;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [2:0] battery_level;
    logic       icon_show;
    logic [2:0] icon_index;
    logic       enter_low_battery;
    logic       go_normal;
    logic       start_alarm;
    logic       primary_low;
    logic       low_voltage;
    logic       cancel_call;
  } res_t;

endpackage

`default_nettype wire

// ----- design/bvm_fifo.sv -----
// small register queue with simultaneous push and pop
`default_nettype none

module bvm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/bvm_front.sv -----
// front end: configuration registers and sample classification
`default_nettype none

module bvm_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  input  wire logic [9:0] sample_i,
  input  wire logic       start_phase_i,
  input  wire logic       menu_active_i,
  output bvm_pkg::cmd_t   cmd_o,
  output logic [7:0]      debounce_limit_o
);

  logic [7:0]    debounce_limit_q;
  logic [9:0]    valid_floor_q;
  logic          above_floor;
  logic          band_hit;
  logic [2:0]    band;
  bvm_pkg::cls_e cls;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_limit_q <= bvm_pkg::DEBOUNCE_LIMIT_RST;
      valid_floor_q    <= bvm_pkg::VALID_FLOOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bvm_pkg::CFG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_data_i[7:0];
        bvm_pkg::CFG_VALID_FLOOR:    valid_floor_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign debounce_limit_o = debounce_limit_q;
  assign above_floor      = (sample_i >= valid_floor_q);

  // level band, gaps give no hit
  always_comb begin
    band_hit = 1'b1;
    band     = 3'd0;
    priority if (sample_i <= bvm_pkg::V_L0_MAX && above_floor) begin
      band = 3'd0;
    end else if (sample_i <= bvm_pkg::V_L1_MAX && sample_i > bvm_pkg::V_L0_MAX) begin
      band = 3'd1;
    end else if (sample_i <= bvm_pkg::V_L2_MAX && sample_i > bvm_pkg::V_L2_LO) begin
      band = 3'd2;
    end else if (sample_i <= bvm_pkg::V_L3_MAX && sample_i > bvm_pkg::V_L3_LO) begin
      band = 3'd3;
    end else if (sample_i <= bvm_pkg::V_L4_MAX && sample_i > bvm_pkg::V_L4_LO) begin
      band = 3'd4;
    end else if (sample_i <= bvm_pkg::V_L5_MAX && sample_i > bvm_pkg::V_L5_LO) begin
      band = 3'd5;
    end else begin
      band_hit = 1'b0;
    end
  end

  // sample class
  always_comb begin
    priority if (start_phase_i) begin
      cls = (sample_i <= bvm_pkg::V_START_MAX && above_floor)
            ? bvm_pkg::CLS_START_LOW : bvm_pkg::CLS_START_OTHER;
    end else if (sample_i <= bvm_pkg::V_CRIT_MAX && above_floor) begin
      cls = bvm_pkg::CLS_CRIT;
    end else if (sample_i < bvm_pkg::V_START_MAX && sample_i > bvm_pkg::V_CRIT_MAX) begin
      cls = bvm_pkg::CLS_WARN;
    end else begin
      cls = bvm_pkg::CLS_OTHER;
    end
  end

  // command beat for the back end
  assign cmd_o = '{cls: cls, band_hit: band_hit, band: band, menu_active: menu_active_i};

endmodule

`default_nettype wire

// ----- design/bvm_back.sv -----
// back end: level, debounce counters, flags and result build
`default_nettype none

module bvm_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_empty_i,
  input  wire bvm_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  wire logic [7:0] debounce_limit_i,
  input  wire logic       res_full_i,
  output logic            res_push_o,
  output bvm_pkg::res_t   res_o
);

`include "battery_voltage_monitor_assert.svh"

  logic [2:0] level_q, level_d;
  logic [7:0] crit_cnt_q, crit_cnt_d;
  logic [7:0] warn_cnt_q, warn_cnt_d;
  logic [7:0] start_cnt_q, start_cnt_d;
  logic       low_volt_q, low_volt_d;
  logic       start_alarm_q, start_alarm_d;
  logic       primary_low_q, primary_low_d;
  logic [7:0] crit_inc, warn_inc, start_inc;
  logic       step;

  // one command per beat while there is room for its result
  assign step       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = step;
  assign res_push_o = step;

  assign crit_inc  = crit_cnt_q + 8'd1;
  assign warn_inc  = warn_cnt_q + 8'd1;
  assign start_inc = (start_cnt_q == 8'hFF) ? start_cnt_q : start_cnt_q + 8'd1;

  // state update and result fields
  always_comb begin
    level_d       = level_q;
    crit_cnt_d    = crit_cnt_q;
    warn_cnt_d    = warn_cnt_q;
    start_cnt_d   = start_cnt_q;
    low_volt_d    = low_volt_q;
    start_alarm_d = start_alarm_q;
    primary_low_d = primary_low_q;
    res_o         = '0;
    unique case (cmd_i.cls)
      bvm_pkg::CLS_START_LOW, bvm_pkg::CLS_START_OTHER: begin
        if (cmd_i.cls == bvm_pkg::CLS_START_LOW) begin
          start_cnt_d = start_inc;
          if (start_inc > debounce_limit_i) begin
            start_alarm_d = 1'b1;
          end
        end else begin
          start_cnt_d = '0;
        end
        if (cmd_i.band_hit) begin
          level_d          = cmd_i.band;
          res_o.icon_show  = 1'b1;
          res_o.icon_index = cmd_i.band;
        end
      end
      bvm_pkg::CLS_CRIT: begin
        crit_cnt_d = crit_inc;
        if (crit_inc >= debounce_limit_i) begin
          res_o.icon_show         = 1'b1;
          res_o.enter_low_battery = 1'b1;
          low_volt_d              = 1'b1;
          crit_cnt_d              = '0;
        end
        primary_low_d = 1'b0;
        warn_cnt_d    = '0;
      end
      bvm_pkg::CLS_WARN: begin
        warn_cnt_d = warn_inc;
        if (warn_inc >= debounce_limit_i) begin
          res_o.icon_show = 1'b1;
          res_o.go_normal = 1'b1;
          primary_low_d   = 1'b1;
          warn_cnt_d      = '0;
        end
      end
      bvm_pkg::CLS_OTHER: begin
        primary_low_d   = 1'b0;
        warn_cnt_d      = '0;
        res_o.go_normal = 1'b1;
        if (cmd_i.band_hit) begin
          level_d = cmd_i.band;
          if (!cmd_i.menu_active) begin
            res_o.icon_show  = 1'b1;
            res_o.icon_index = cmd_i.band;
          end
        end
        if (low_volt_q) begin
          res_o.cancel_call = 1'b1;
          low_volt_d        = 1'b0;
        end
      end
      default: ;
    endcase
    res_o.battery_level = level_d;
    res_o.start_alarm   = start_alarm_d;
    res_o.primary_low   = primary_low_d;
    res_o.low_voltage   = low_volt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= '0;
      crit_cnt_q    <= '0;
      warn_cnt_q    <= '0;
      start_cnt_q   <= '0;
      low_volt_q    <= 1'b0;
      start_alarm_q <= 1'b0;
      primary_low_q <= 1'b0;
    end else if (step) begin
      level_q       <= level_d;
      crit_cnt_q    <= crit_cnt_d;
      warn_cnt_q    <= warn_cnt_d;
      start_cnt_q   <= start_cnt_d;
      low_volt_q    <= low_volt_d;
      start_alarm_q <= start_alarm_d;
      primary_low_q <= primary_low_d;
    end
  end

  // checks on the back end state
  `BVM_ASSERT_NOW(a_level_range, 1'b1, level_q <= 3'd5, "battery level out of range")
  `BVM_ASSERT_NEXT(a_alarm_sticky, start_alarm_q, start_alarm_q, "start alarm cleared")
  `BVM_ASSERT_NOW(a_cancel_after_low, res_push_o && res_o.cancel_call,
                  low_volt_q && !res_o.low_voltage, "cancel without prior critical low")
  `BVM_ASSERT_NEXT(a_start_sat, step && start_cnt_q == 8'hFF &&
                   cmd_i.cls == bvm_pkg::CLS_START_LOW, start_cnt_q == 8'hFF,
                   "start counter wrapped")

endmodule

`default_nettype wire

// ----- design/battery_voltage_monitor.sv -----
// top level of the battery voltage monitor
//
// Input side is a queue: drive sample_i, start_phase_i and menu_active_i with
// push high; a beat is taken at a clock edge where push is high and full low.
// Result side is a queue too: while empty is low the oldest result sits on the
// result ports and is taken at an edge where pop is high.
// One result comes out for every sample, in order.
// A sample is classified on the way into the command queue; the back end
// evaluates it once it heads that queue and the result queue has room, and
// its result is registered in the result queue before it reaches the ports.
// Throughput: one sample per cycle, sustained, as long as results are popped;
// each back end step is one counter and flag update.
// A stalled receiver fills the result queue, then the command queue, and
// full rises; nothing is lost.
// Configuration: cfg_valid_i with cfg_index_i (0 debounce limit, 1 valid
// floor) and cfg_data_i; cfg_ready_o is always high. Write only while idle.
// Reset clears the level, counters, flags and both queues and loads the
// debounce limit with 100 and the valid floor with 200.
`default_nettype none

module battery_voltage_monitor #(
  parameter int unsigned CMD_DEPTH = bvm_pkg::CMD_DEPTH,
  parameter int unsigned RES_DEPTH = bvm_pkg::RES_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [9:0] sample_i,
  input  wire logic       start_phase_i,
  input  wire logic       menu_active_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      battery_level_o,
  output logic            icon_show_o,
  output logic [2:0]      icon_index_o,
  output logic            enter_low_battery_o,
  output logic            go_normal_o,
  output logic            start_alarm_o,
  output logic            primary_low_o,
  output logic            low_voltage_o,
  output logic            cancel_call_o
);

  localparam int unsigned CMD_W = $bits(bvm_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(bvm_pkg::res_t);

  bvm_pkg::cmd_t   cmd_in, cmd_out;
  bvm_pkg::res_t   res_in, res_out;
  logic [CMD_W-1:0] cmd_rdata;
  logic [RES_W-1:0] res_rdata;
  logic [7:0]      debounce_limit;
  logic            cmd_empty, cmd_pop;
  logic            res_full, res_push;

  assign cfg_ready_o = 1'b1;

  // classify and hold configuration
  bvm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample_i),
    .start_phase_i    (start_phase_i),
    .menu_active_i    (menu_active_i),
    .cmd_o            (cmd_in),
    .debounce_limit_o (debounce_limit)
  );

  // queue between front and back
  bvm_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_out = bvm_pkg::cmd_t'(cmd_rdata);

  // state update
  bvm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_empty_i      (cmd_empty),
    .cmd_i            (cmd_out),
    .cmd_pop_o        (cmd_pop),
    .debounce_limit_i (debounce_limit),
    .res_full_i       (res_full),
    .res_push_o       (res_push),
    .res_o            (res_in)
  );

  // result queue towards the receiver
  bvm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out = bvm_pkg::res_t'(res_rdata);

  assign battery_level_o     = res_out.battery_level;
  assign icon_show_o         = res_out.icon_show;
  assign icon_index_o        = res_out.icon_index;
  assign enter_low_battery_o = res_out.enter_low_battery;
  assign go_normal_o         = res_out.go_normal;
  assign start_alarm_o       = res_out.start_alarm;
  assign primary_low_o       = res_out.primary_low;
  assign low_voltage_o       = res_out.low_voltage;
  assign cancel_call_o       = res_out.cancel_call;

endmodule

`default_nettype wire

// ----- bench/tb_battery_voltage_monitor.sv -----
// self-checking testbench for the battery voltage monitor
`default_nettype none

module tb_battery_voltage_monitor;

  // thresholds in adc counts, kept apart from the design's own copies
  localparam int CRIT_TOP  = 345;
  localparam int START_TOP = 355;
  localparam int L0_TOP    = 350;
  localparam int L1_TOP    = 360;
  localparam int L2_BOT    = 365;
  localparam int L2_TOP    = 375;
  localparam int L3_BOT    = 380;
  localparam int L3_TOP    = 390;
  localparam int L4_BOT    = 395;
  localparam int L4_TOP    = 405;
  localparam int L5_BOT    = 410;
  localparam int L5_TOP    = 500;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int EDGE_N        = 31;

  // running model of the monitor, with the readings still owed by the block
  class battery_checker;
    logic [7:0]    deb_limit;
    logic [9:0]    floor_v;
    logic [2:0]    lvl;
    logic [7:0]    crit_cnt;
    logic [7:0]    warn_cnt;
    logic [7:0]    start_cnt;
    bit            low_v;
    bit            alarm;
    bit            prim_low;
    bvm_pkg::res_t owed_readings[$];
    int            errors;
    int            reading_no;

    function new();
      deb_limit  = bvm_pkg::DEBOUNCE_LIMIT_RST;
      floor_v    = bvm_pkg::VALID_FLOOR_RST;
      lvl        = '0;
      crit_cnt   = '0;
      warn_cnt   = '0;
      start_cnt  = '0;
      low_v      = 1'b0;
      alarm      = 1'b0;
      prim_low   = 1'b0;
      errors     = 0;
      reading_no = 0;
    endfunction

    function void write_reg(logic idx, logic [9:0] data);
      if (idx == bvm_pkg::CFG_DEBOUNCE_LIMIT) begin
        deb_limit = data[7:0];
      end else begin
        floor_v = data;
      end
    endfunction

    // band 0..5, or -1 inside a gap where the level is held
    function int level_band(int v);
      if (v <= L0_TOP && v >= int'(floor_v)) return 0;
      if (v <= L1_TOP && v > L0_TOP) return 1;
      if (v <= L2_TOP && v > L2_BOT) return 2;
      if (v <= L3_TOP && v > L3_BOT) return 3;
      if (v <= L4_TOP && v > L4_BOT) return 4;
      if (v <= L5_TOP && v > L5_BOT) return 5;
      return -1;
    endfunction

    // advance the model by one accepted sample and queue the reading it owes
    function void take_sample(int v, bit st, bit menu);
      bvm_pkg::res_t r;
      int            b;
      r = '0;
      if (st) begin
        // start phase: saturating debounce towards the sticky alarm
        if (v <= START_TOP && v >= int'(floor_v)) begin
          if (start_cnt != 8'd255) start_cnt = start_cnt + 8'd1;
          if (start_cnt > deb_limit) alarm = 1'b1;
        end else begin
          start_cnt = '0;
        end
        b = level_band(v);
        if (b >= 0) begin
          lvl          = 3'(b);
          r.icon_show  = 1'b1;
          r.icon_index = 3'(b);
        end
      end else if (v <= CRIT_TOP && v >= int'(floor_v)) begin
        // critical band
        crit_cnt = crit_cnt + 8'd1;
        if (crit_cnt >= deb_limit) begin
          r.icon_show         = 1'b1;
          r.enter_low_battery = 1'b1;
          low_v               = 1'b1;
          crit_cnt            = '0;
        end
        prim_low = 1'b0;
        warn_cnt = '0;
      end else if (v < START_TOP && v > CRIT_TOP) begin
        // warning band
        warn_cnt = warn_cnt + 8'd1;
        if (warn_cnt >= deb_limit) begin
          r.icon_show = 1'b1;
          r.go_normal = 1'b1;
          prim_low    = 1'b1;
          warn_cnt    = '0;
        end
      end else begin
        // healthy or unreadable sample: counts as recovery
        prim_low    = 1'b0;
        warn_cnt    = '0;
        r.go_normal = 1'b1;
        b = level_band(v);
        if (b >= 0) begin
          lvl = 3'(b);
          if (!menu) begin
            r.icon_show  = 1'b1;
            r.icon_index = 3'(b);
          end
        end
        if (low_v) begin
          r.cancel_call = 1'b1;
          low_v         = 1'b0;
        end
      end
      r.battery_level = lvl;
      r.start_alarm   = alarm;
      r.primary_low   = prim_low;
      r.low_voltage   = low_v;
      owed_readings.push_back(r);
    endfunction

    function int pending_count();
      return owed_readings.size();
    endfunction

    task report(string msg);
      $display("reading %0d mismatch: %s", reading_no, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [2:0] got, logic [2:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // compare one popped reading with the oldest one owed
    task check_reading(bvm_pkg::res_t got);
      bvm_pkg::res_t want;
      if (owed_readings.size() == 0) begin
        report("reading popped with none owed");
      end else begin
        want = owed_readings.pop_front();
        cmp_field("battery_level", got.battery_level, want.battery_level);
        cmp_field("icon_show", 3'(got.icon_show), 3'(want.icon_show));
        cmp_field("icon_index", got.icon_index, want.icon_index);
        cmp_field("enter_low_battery", 3'(got.enter_low_battery),
                  3'(want.enter_low_battery));
        cmp_field("go_normal", 3'(got.go_normal), 3'(want.go_normal));
        cmp_field("start_alarm", 3'(got.start_alarm), 3'(want.start_alarm));
        cmp_field("primary_low", 3'(got.primary_low), 3'(want.primary_low));
        cmp_field("low_voltage", 3'(got.low_voltage), 3'(want.low_voltage));
        cmp_field("cancel_call", 3'(got.cancel_call), 3'(want.cancel_call));
      end
      reading_no++;
    endtask
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i   = 1'b0;
  logic [9:0] cfg_data_i    = '0;
  logic       push          = 1'b0;
  logic       full;
  logic [9:0] sample_i      = '0;
  logic       start_phase_i = 1'b0;
  logic       menu_active_i = 1'b0;
  logic       empty;
  logic       pop           = 1'b0;
  logic [2:0] battery_level_o;
  logic       icon_show_o;
  logic [2:0] icon_index_o;
  logic       enter_low_battery_o;
  logic       go_normal_o;
  logic       start_alarm_o;
  logic       primary_low_o;
  logic       low_voltage_o;
  logic       cancel_call_o;

  bvm_pkg::res_t seen;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  bit   hold_rx = 1'b0;
  int   cycles  = 0;
  int   edge_vals [EDGE_N] = '{0, 199, 200, 201, 344, 345, 346, 350, 351, 354, 355,
                               356, 360, 361, 365, 366, 375, 376, 380, 381, 390,
                               391, 395, 396, 405, 406, 410, 411, 500, 501, 1023};

  battery_checker sb = new();

  battery_voltage_monitor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .push               (push),
    .full               (full),
    .sample_i           (sample_i),
    .start_phase_i      (start_phase_i),
    .menu_active_i      (menu_active_i),
    .empty              (empty),
    .pop                (pop),
    .battery_level_o    (battery_level_o),
    .icon_show_o        (icon_show_o),
    .icon_index_o       (icon_index_o),
    .enter_low_battery_o(enter_low_battery_o),
    .go_normal_o        (go_normal_o),
    .start_alarm_o      (start_alarm_o),
    .primary_low_o      (primary_low_o),
    .low_voltage_o      (low_voltage_o),
    .cancel_call_o      (cancel_call_o)
  );

  assign seen = {battery_level_o, icon_show_o, icon_index_o, enter_low_battery_o,
                 go_normal_o, start_alarm_o, primary_low_o, low_voltage_o,
                 cancel_call_o};

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watch every handshake at the edge it completes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (push && !full) sb.take_sample(int'(sample_i), start_phase_i, menu_active_i);
      if (pop && !empty) sb.check_reading(seen);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // value in [lo, hi], or anywhere when that range is empty
  function automatic int rand_in(int lo, int hi);
    if (lo > hi) return $urandom_range(1023, 0);
    return $urandom_range(hi, lo);
  endfunction

  // samples around the level bands and the floor
  function automatic int level_sample(int flr);
    case ($urandom_range(2, 0))
      0: return edge_vals[$urandom_range(EDGE_N - 1, 0)];
      1: return $urandom_range(L5_TOP, L0_TOP + 1);
      default: return (flr == 0) ? 0 : flr - int'($urandom_range(1, 0));
    endcase
  endfunction

  task automatic send_sample(int v, bit st, bit m);
    int g;
    push          <= 1'b1;
    sample_i      <= 10'(v);
    start_phase_i <= st;
    menu_active_i <= m;
    do @(posedge clk_i); while (full);
    g = pick_gap(tx_idle);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // sender pauses until every owed reading has been popped
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, back to back, once the block has gone quiet
  task automatic set_config(int lim, int flr);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= bvm_pkg::CFG_DEBOUNCE_LIMIT;
    cfg_data_i  <= 10'(lim);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= bvm_pkg::CFG_VALID_FLOOR;
    cfg_data_i  <= 10'(flr);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // debounce runs of random content, mixed with band samples and noise
  task automatic run_phase(int lim, int flr, int n, bit hold);
    int made;
    int kind;
    int len;
    made = 0;
    set_config(lim, flr);
    tx_idle = ($urandom_range(3, 0) != 0);
    rx_idle = ($urandom_range(3, 0) != 0);
    if (hold) hold_rx = 1'b1;
    while (made < n) begin
      kind = $urandom_range(9, 0);
      len  = (kind <= 5) ? lim - 1 + int'($urandom_range(3, 0)) : $urandom_range(4, 1);
      if (len < 1) len = 1;
      for (int i = 0; i < len; i++) begin
        case (kind)
          0, 1: send_sample(rand_in(flr, CRIT_TOP), 1'b0, 1'($urandom_range(1, 0)));
          2, 3: send_sample(rand_in(CRIT_TOP + 1, START_TOP - 1), 1'b0,
                            1'($urandom_range(1, 0)));
          4, 5: send_sample(rand_in(flr, START_TOP), 1'b1, 1'($urandom_range(1, 0)));
          6, 7: send_sample(level_sample(flr), 1'($urandom_range(1, 0)),
                            1'($urandom_range(1, 0)));
          8: send_sample($urandom_range(1023, 0), 1'($urandom_range(1, 0)),
                         1'($urandom_range(1, 0)));
          default: send_sample((flr > 0) ? rand_in(0, flr - 1) : 0, 1'b0,
                               1'($urandom_range(1, 0)));
        endcase
      end
      made += len;
    end
  endtask

  // result side: random pops, plus one long hold when asked
  initial begin : rx_side
    int g;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      g = pick_gap(rx_idle);
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin : tx_side
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, band edges, both flags, reset settings
    send_sample(0, 1'b0, 1'b0);
    send_sample(1023, 1'b0, 1'b0);
    send_sample(199, 1'b0, 1'b1);
    send_sample(200, 1'b0, 1'b0);
    send_sample(345, 1'b0, 1'b0);
    send_sample(346, 1'b0, 1'b0);
    send_sample(354, 1'b0, 1'b1);
    send_sample(355, 1'b0, 1'b0);
    send_sample(350, 1'b1, 1'b0);
    send_sample(351, 1'b1, 1'b1);
    send_sample(355, 1'b1, 1'b0);
    send_sample(356, 1'b1, 1'b0);
    send_sample(360, 1'b0, 1'b1);
    send_sample(361, 1'b0, 1'b0);
    send_sample(366, 1'b0, 1'b0);
    send_sample(375, 1'b1, 1'b0);
    send_sample(380, 1'b0, 1'b0);
    send_sample(381, 1'b0, 1'b0);
    send_sample(390, 1'b1, 1'b1);
    send_sample(395, 1'b0, 1'b0);
    send_sample(396, 1'b0, 1'b0);
    send_sample(405, 1'b0, 1'b0);
    send_sample(410, 1'b0, 1'b0);
    send_sample(411, 1'b0, 1'b0);
    send_sample(500, 1'b0, 1'b0);
    send_sample(501, 1'b1, 1'b0);

    // start counter must saturate: long start run at the top limit, then
    // one more low start sample once the limit drops below the count
    set_config(255, 200);
    repeat (300) send_sample(rand_in(200, START_TOP), 1'b1, 1'($urandom_range(1, 0)));
    set_config(254, 200);
    send_sample(rand_in(200, START_TOP), 1'b1, 1'b0);

    // random phases across limits and floors, extremes included
    run_phase(1, 200, 200, 1'b0);
    run_phase(2, 0, 200, 1'b0);
    run_phase(3, 1023, 150, 1'b0);
    run_phase(5, 300, 200, 1'b1);
    run_phase(255, 200, 150, 1'b0);
    run_phase($urandom_range(8, 1), $urandom_range(360, 150), 200, 1'b0);
    run_phase(4, 345, 150, 1'b0);
    run_phase(100, 200, 60, 1'b0);

    wait_idle();
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/bvm_pkg.sv
design/bvm_fifo.sv
design/bvm_front.sv
design/bvm_back.sv
design/battery_voltage_monitor.sv
bench/tb_battery_voltage_monitor.sv
